/* src/byte_alu_nzc_flags_top_macros.svh */
// ----------------------------------------------------------------------------
// Byte ALU assertion macros
// Assertion macros used by the byte ALU top level.
// ----------------------------------------------------------------------------
`ifndef BYTE_ALU_NZC_FLAGS_TOP_MACROS_SVH
`define BYTE_ALU_NZC_FLAGS_TOP_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define BNZC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define BNZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/bnzc_pkg.sv */
// ----------------------------------------------------------------------------
// Byte ALU package
// Operation codes, flag and stage types shared by the byte ALU modules.
// ----------------------------------------------------------------------------
package bnzc_pkg;

   localparam int DATA_WIDTH = 8;
   localparam int KIND_WIDTH = 4;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LOAD  = 4'd0,
      KIND_STORE = 4'd1,
      KIND_INC   = 4'd2,
      KIND_DEC   = 4'd3,
      KIND_ADC   = 4'd4,
      KIND_SBC   = 4'd5,
      KIND_CMP   = 4'd6,
      KIND_AND   = 4'd7,
      KIND_OR    = 4'd8,
      KIND_XOR   = 4'd9,
      KIND_LSR   = 4'd10,
      KIND_ASL   = 4'd11,
      KIND_ROL   = 4'd12,
      KIND_ROR   = 4'd13,
      KIND_BIT   = 4'd14
   } kind_type;

   typedef logic [DATA_WIDTH-1:0] byte_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
   } flags_type;

   // Contents of the input register.
   typedef struct packed {
      logic     valid;
      kind_type kind;
      byte_type first_value;
      byte_type second_value;
   } stage_type;

endpackage

/* src/byte_alu_nzc_flags_top.sv */
// ----------------------------------------------------------------------------
// Byte ALU with N, Z and C flags
// Eight-bit ALU in the style of a classic processor, one operation per word.
// ----------------------------------------------------------------------------
// Each request word carries an operation code, an accumulator byte and an
// operand byte. Each accepted word produces exactly one response word with the
// result byte and the negative, zero and carry flags as they stand afterwards.
// The flags live in the block and feed the next operation (carry-in, and the
// flags that an operation leaves alone).
// A word passes through an input register and then a response register, and
// the response is offered from the response register. One word is taken every
// cycle while the receiver does not stall; the flags feed back from the flag
// register through the ALU.
// The receiver may stall at will: the response register holds its word, the
// input register keeps the following one, and only then does req_stall rise.
// Reset clears the flags and empties both registers.
// ----------------------------------------------------------------------------
module byte_alu_nzc_flags_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bnzc_pkg::KIND_WIDTH-1:0]   req_kind,
   input  logic [bnzc_pkg::DATA_WIDTH-1:0]   req_first_value,
   input  logic [bnzc_pkg::DATA_WIDTH-1:0]   req_second_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bnzc_pkg::DATA_WIDTH-1:0]   rsp_result,
   output logic                              rsp_negative_out,
   output logic                              rsp_zero_out,
   output logic                              rsp_carry_out
);
   import bnzc_pkg::*;

   `include "byte_alu_nzc_flags_top_macros.svh"

   stage_type stage;
   logic      advance;
   byte_type  alu_result;
   flags_type alu_flags;
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  result_ff;
   flags_type flags_ff;

   // A word leaves the input register when the response register is free or emptying.
   assign advance = stage.valid && (!rsp_valid_ff || !rsp_stall);

   bnzc_input_stage u_input_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .advance          (advance),
      .stage            (stage)
   );

   bnzc_alu_core u_alu_core (
      .kind         (stage.kind),
      .first_value  (stage.first_value),
      .second_value (stage.second_value),
      .flags_now    (flags_ff),
      .result       (alu_result),
      .flags_next   (alu_flags)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The flags change only as a word moves into the response register, so they
   // always match the word held there.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            flags_ff <= alu_flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= alu_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = result_ff;
   assign rsp_negative_out = flags_ff.n;
   assign rsp_zero_out     = flags_ff.z;
   assign rsp_carry_out    = flags_ff.c;

   `BNZC_ASSERT_NEXT(a_flags_hold_when_idle, clock, reset, !advance, $stable(flags_ff),
                     "flags changed without a word moving")
   `BNZC_ASSERT_NEXT(a_store_keeps_flags, clock, reset,
                     advance && stage.kind == KIND_STORE, $stable(flags_ff),
                     "store altered the flags")
   `BNZC_ASSERT_NEXT(a_incdec_keep_carry, clock, reset,
                     advance && (stage.kind == KIND_INC || stage.kind == KIND_DEC),
                     $stable(flags_ff.c), "increment or decrement altered carry")
   `BNZC_ASSERT_NEXT(a_held_word_kept, clock, reset, stage.valid && !advance, stage.valid,
                     "input word lost while waiting")
   `BNZC_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
                     stage.valid && rsp_valid_ff, "request stalled with room to spare")

endmodule

/* src/bnzc_input_stage.sv */
// ----------------------------------------------------------------------------
// Byte ALU input register
// Captures one request word and holds it until the ALU stage takes it.
// ----------------------------------------------------------------------------
module bnzc_input_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bnzc_pkg::KIND_WIDTH-1:0]     req_kind,
   input  logic [bnzc_pkg::DATA_WIDTH-1:0]     req_first_value,
   input  logic [bnzc_pkg::DATA_WIDTH-1:0]     req_second_value,
   input  logic                                advance,
   output bnzc_pkg::stage_type                 stage
);
   import bnzc_pkg::*;

   logic     valid_ff, valid_in;
   kind_type kind_ff;
   byte_type first_ff;
   byte_type second_ff;
   logic     load;

   // The register may refill in the same cycle as its word moves on.
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         kind_ff   <= kind_type'(req_kind);
         first_ff  <= req_first_value;
         second_ff <= req_second_value;
      end
   end

   assign stage.valid        = valid_ff;
   assign stage.kind         = kind_ff;
   assign stage.first_value  = first_ff;
   assign stage.second_value = second_ff;

endmodule

/* src/bnzc_alu_core.sv */
// ----------------------------------------------------------------------------
// Byte ALU datapath
// Computes the result byte and the next N, Z and C flags for one operation.
// ----------------------------------------------------------------------------
module bnzc_alu_core (
   input  bnzc_pkg::kind_type                kind,
   input  logic [bnzc_pkg::DATA_WIDTH-1:0]   first_value,
   input  logic [bnzc_pkg::DATA_WIDTH-1:0]   second_value,
   input  bnzc_pkg::flags_type               flags_now,
   output logic [bnzc_pkg::DATA_WIDTH-1:0]   result,
   output bnzc_pkg::flags_type               flags_next
);
   import bnzc_pkg::*;

   logic [DATA_WIDTH-1:0] add_operand;
   logic                  add_cin;
   logic [DATA_WIDTH:0]   add_sum;
   logic                  subtracting;

   // Subtraction adds the inverted operand, so bit 8 is already "no borrow".
   assign subtracting = (kind == KIND_SBC) || (kind == KIND_CMP);
   assign add_operand = subtracting ? ~second_value : second_value;
   assign add_cin     = (kind == KIND_CMP) ? 1'b1 : flags_now.c;
   assign add_sum     = {1'b0, first_value} + {1'b0, add_operand}
                      + {{DATA_WIDTH{1'b0}}, add_cin};

   always_comb begin
      byte_type value;
      value      = '0;
      result     = '0;
      flags_next = flags_now;
      unique case (kind)
         KIND_LOAD:  value = second_value;
         KIND_STORE: value = second_value;
         KIND_INC:   value = second_value + 8'd1;
         KIND_DEC:   value = second_value - 8'd1;
         KIND_ADC, KIND_SBC, KIND_CMP: begin
            value        = add_sum[DATA_WIDTH-1:0];
            flags_next.c = add_sum[DATA_WIDTH];
         end
         KIND_AND:   value = first_value & second_value;
         KIND_OR:    value = first_value | second_value;
         KIND_XOR:   value = first_value ^ second_value;
         KIND_LSR: begin
            value        = {1'b0, second_value[DATA_WIDTH-1:1]};
            flags_next.c = second_value[0];
         end
         KIND_ASL: begin
            value        = {second_value[DATA_WIDTH-2:0], 1'b0};
            flags_next.c = second_value[DATA_WIDTH-1];
         end
         KIND_ROL: begin
            value        = {second_value[DATA_WIDTH-2:0], flags_now.c};
            flags_next.c = second_value[DATA_WIDTH-1];
         end
         KIND_ROR: begin
            value        = {flags_now.c, second_value[DATA_WIDTH-1:1]};
            flags_next.c = second_value[0];
         end
         KIND_BIT:   value = first_value & second_value;
         default:    value = '0;
      endcase

      // Everything but store, bit test and the unused code sets N and Z from the byte.
      if (kind == KIND_BIT) begin
         flags_next.n = second_value[DATA_WIDTH-1];
         flags_next.z = (value == '0);
      end else if (kind != KIND_STORE && kind <= KIND_ROR) begin
         flags_next.n = value[DATA_WIDTH-1];
         flags_next.z = (value == '0);
      end

      // Compare and bit test return a zero byte; so does the unused code.
      if (kind != KIND_CMP && kind != KIND_BIT && kind <= KIND_ROR) begin
         result = value;
      end
   end

endmodule

/* test/byte_alu_nzc_flags_top_tb.sv */
// ----------------------------------------------------------------------------
// Byte ALU with N, Z and C flags: testbench
// Drives operation words through the request channel and checks each
// response word against a local model of the ALU and its flag register.
// ----------------------------------------------------------------------------
module byte_alu_nzc_flags_top_tb;
   import bnzc_pkg::*;

   // Operation code that the block treats as a no-operation.
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED = 4'd15;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      byte_type result;
      logic     negative;
      logic     zero;
      logic     carry;
   } alu_word_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KIND_WIDTH-1:0] req_kind;
   byte_type              req_first_value;
   byte_type              req_second_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   byte_type              rsp_result;
   logic                  rsp_negative_out;
   logic                  rsp_zero_out;
   logic                  rsp_carry_out;

   alu_word_type pending_results[$];
   logic      flag_negative = 1'b0;
   logic      flag_zero = 1'b0;
   logic      flag_carry = 1'b0;
   int        error_count = 0;
   int        cycle_count = 0;
   int        sender_idle_pct = 0;
   int        receiver_stall_pct = 0;
   int        hold_off_left = 0;

   byte_alu_nzc_flags_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_negative_out (rsp_negative_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_carry_out    (rsp_carry_out)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the response word for one operation and updates the flags.
   function automatic alu_word_type compute_alu_word(logic [KIND_WIDTH-1:0] kind,
                                                     byte_type a, byte_type m);
      alu_word_type w;
      logic [8:0] wide;
      logic       update_nz;
      w = '0;
      wide = '0;
      update_nz = 1'b1;
      case (kind)
         KIND_LOAD: w.result = m;
         KIND_STORE: begin
            w.result = m;
            update_nz = 1'b0;
         end
         KIND_INC: w.result = m + 8'd1;
         KIND_DEC: w.result = m - 8'd1;
         KIND_ADC: begin
            wide = {1'b0, a} + {1'b0, m} + {8'd0, flag_carry};
            w.result = wide[7:0];
            flag_carry = wide[8];
         end
         KIND_SBC: begin
            // Bit 8 of the nine-bit difference is the borrow.
            wide = {1'b0, a} - {1'b0, m} - {8'd0, ~flag_carry};
            w.result = wide[7:0];
            flag_carry = ~wide[8];
         end
         KIND_CMP: begin
            wide = {1'b0, a} - {1'b0, m};
            flag_carry = ~wide[8];
            flag_negative = wide[7];
            flag_zero = (wide[7:0] == 8'd0);
            update_nz = 1'b0;
         end
         KIND_AND: w.result = a & m;
         KIND_OR:  w.result = a | m;
         KIND_XOR: w.result = a ^ m;
         KIND_LSR: begin
            flag_carry = m[0];
            w.result = {1'b0, m[7:1]};
         end
         KIND_ASL: begin
            flag_carry = m[7];
            w.result = {m[6:0], 1'b0};
         end
         KIND_ROL: begin
            w.result = {m[6:0], flag_carry};
            flag_carry = m[7];
         end
         KIND_ROR: begin
            w.result = {flag_carry, m[7:1]};
            flag_carry = m[0];
         end
         KIND_BIT: begin
            flag_negative = m[7];
            flag_zero = ((a & m) == 8'd0);
            update_nz = 1'b0;
         end
         default: update_nz = 1'b0;
      endcase
      if (update_nz) begin
         flag_negative = w.result[7];
         flag_zero = (w.result == 8'd0);
      end
      w.negative = flag_negative;
      w.zero = flag_zero;
      w.carry = flag_carry;
      return w;
   endfunction

   function automatic byte_type random_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return byte_type'($urandom_range(255));
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Offers one word and returns at the rising edge that accepts it.
   task automatic send_op(input logic [KIND_WIDTH-1:0] kind, input byte_type a,
                          input byte_type m);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_first_value <= a;
      req_second_value <= m;
      do
         @(posedge clock);
      while (req_stall);
      pending_results.push_back(compute_alu_word(kind, a, m));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(KIND_LOAD, 8'h00, 8'h00);
      send_op(KIND_LOAD, 8'hFF, 8'h80);
      send_op(KIND_STORE, 8'h00, 8'hFF);
      send_op(KIND_INC, 8'h00, 8'hFF);
      send_op(KIND_DEC, 8'hFF, 8'h00);
      send_op(KIND_ADC, 8'hFF, 8'h01);
      send_op(KIND_ADC, 8'h7F, 8'h00);
      send_op(KIND_ADC, 8'hFF, 8'hFF);
      send_op(KIND_SBC, 8'h00, 8'h01);
      send_op(KIND_SBC, 8'h50, 8'h10);
      send_op(KIND_SBC, 8'hFF, 8'h00);
      send_op(KIND_CMP, 8'h42, 8'h42);
      send_op(KIND_CMP, 8'h00, 8'hFF);
      send_op(KIND_AND, 8'hF0, 8'h0F);
      send_op(KIND_OR, 8'h00, 8'h00);
      send_op(KIND_XOR, 8'hAA, 8'h55);
      send_op(KIND_LSR, 8'h00, 8'h01);
      send_op(KIND_ASL, 8'h00, 8'h80);
      send_op(KIND_ROL, 8'h00, 8'h80);
      send_op(KIND_ROR, 8'h00, 8'h01);
      send_op(KIND_BIT, 8'h7F, 8'h80);
      send_op(KIND_BIT, 8'hFF, 8'hC0);
      send_op(KIND_UNUSED, 8'hFF, 8'hFF);
      send_op(KIND_ROR, 8'hFF, 8'hFE);
   endtask

   task automatic test_random_ops(input int count);
      logic [KIND_WIDTH-1:0] kind;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(31) == 0)
            kind = KIND_UNUSED;
         else
            kind = KIND_WIDTH'($urandom_range(14));
         send_op(kind, random_byte(), random_byte());
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_left = 150;
      test_random_ops(40);
      wait_for_results();
   endtask

   task automatic test_pause_until_empty();
      sender_idle_pct = 10;
      receiver_stall_pct = 30;
      test_random_ops(20);
      wait_for_results();
      test_random_ops(20);
      wait_for_results();
   endtask

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      alu_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_result !== want.result)
               report_mismatch($sformatf("result %02h, expected %02h",
                                         rsp_result, want.result));
            if (rsp_negative_out !== want.negative)
               report_mismatch($sformatf("negative %b, expected %b",
                                         rsp_negative_out, want.negative));
            if (rsp_zero_out !== want.zero)
               report_mismatch($sformatf("zero %b, expected %b",
                                         rsp_zero_out, want.zero));
            if (rsp_carry_out !== want.carry)
               report_mismatch($sformatf("carry %b, expected %b",
                                         rsp_carry_out, want.carry));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = '0;
      req_first_value = '0;
      req_second_value = '0;
      rsp_stall = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 24;
      receiver_stall_pct = 86;
      test_directed();
      test_random_ops(430);

      sender_idle_pct = 86;
      receiver_stall_pct = 24;
      test_random_ops(430);

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      test_random_ops(400);

      test_backpressure();
      test_pause_until_empty();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/bnzc_pkg.sv
src/bnzc_input_stage.sv
src/bnzc_alu_core.sv
src/byte_alu_nzc_flags_top.sv
test/byte_alu_nzc_flags_top_tb.sv
